// File: sv/assert_macros.svh
// Assertion helpers used by the checker file ccs_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising clock, off while reset is applied.
`define CCS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication check: when ante holds, cons must hold on the next edge.
`define CCS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/ccs_pkg.sv
package ccs_pkg;

  localparam int DIGIT_COUNT = 6;
  localparam int IDX_W       = $clog2(DIGIT_COUNT);

  localparam int SEG_W   = 7;
  localparam int POINT_W = 2;

  // year mod 100 by reciprocal: floor(y * 5243 / 2^19) == floor(y / 100) for 12-bit y
  localparam logic [12:0] YEAR_RECIP = 13'd5243;
  localparam int          YEAR_SHIFT = 19;

  // floor(v * 103 / 2^10) == floor(v / 10) for v below 128
  localparam logic [6:0] TENS_RECIP = 7'd103;
  localparam int         TENS_SHIFT = 10;

  typedef enum logic [1:0] {
    CMD_SCAN   = 2'd0,
    CMD_TOGGLE = 2'd1,
    CMD_LOAD   = 2'd2
  } cmd_e;

  localparam logic [POINT_W-1:0] POINT_ALL_OFF = 2'd3;
  localparam logic [POINT_W-1:0] POINT_ALL_ON  = 2'd0;

  typedef struct packed {
    logic [SEG_W-1:0]       segments;
    logic [DIGIT_COUNT-1:0] digit_select;
    logic [POINT_W-1:0]     point_off;
  } res_t;

  function automatic logic [SEG_W-1:0] seg_lookup(input logic [3:0] digit);
    logic [SEG_W-1:0] seg;
    case (digit)
      4'd0:    seg = 7'h40;
      4'd1:    seg = 7'h79;
      4'd2:    seg = 7'h24;
      4'd3:    seg = 7'h30;
      4'd4:    seg = 7'h19;
      4'd5:    seg = 7'h12;
      4'd6:    seg = 7'h03;
      4'd7:    seg = 7'h78;
      4'd8:    seg = 7'h00;
      4'd9:    seg = 7'h18;
      default: seg = 7'h40;
    endcase
    return seg;
  endfunction

endpackage

// File: sv/clock_calendar_7seg_scanner.sv
// Channel | Handshake                   | Payload
// in      | in_valid_i / in_stall_o     | command_i, second_i, minute_i, hour_i,
//         |                             | day_of_month_i, month_i, year_i
// out     | out_valid_o / out_stall_i   | segments_o, digit_select_o, point_off_o
//
// One item per cycle while in_stall_o is low; scan results are registered.
// Toggle and load commands update held state and give no result.
// Output register plus one skid entry; in_stall_o rises only when the skid is full.
// rst_ni clears scan index, view, held clock values and both valid flags.
module clock_calendar_7seg_scanner (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic [1:0]                            command_i,
  input  logic [5:0]                            second_i,
  input  logic [5:0]                            minute_i,
  input  logic [4:0]                            hour_i,
  input  logic [4:0]                            day_of_month_i,
  input  logic [3:0]                            month_i,
  input  logic [11:0]                           year_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic [ccs_pkg::SEG_W-1:0]             segments_o,
  output logic [ccs_pkg::DIGIT_COUNT-1:0]       digit_select_o,
  output logic [ccs_pkg::POINT_W-1:0]           point_off_o
);
  import ccs_pkg::*;

  logic [IDX_W-1:0] scan_idx_q, scan_idx_d;
  logic             show_date_q, show_date_d;
  logic [5:0]       sec_q, min_q;
  logic [4:0]       hour_q, day_q;
  logic [3:0]       month_q;
  logic [6:0]       year_lo_q;

  logic             out_valid_q, skid_valid_q;
  res_t             out_q, skid_q;

  logic             in_xfer, do_scan, do_toggle, do_load, out_free;

  logic [24:0]      yr_prod;
  logic [5:0]       yr_quot;
  logic [11:0]      yr_rem;

  logic [IDX_W-1:0] pos;
  logic [6:0]       val;
  logic [13:0]      tens_prod;
  logic [3:0]       tens, ones, digit;
  res_t             res;

  assign in_stall_o = skid_valid_q;
  assign in_xfer    = in_valid_i && !in_stall_o;

  always_comb begin
    do_scan   = 1'b0;
    do_toggle = 1'b0;
    do_load   = 1'b0;
    unique case (command_i)
      CMD_SCAN:   do_scan   = in_xfer;
      CMD_TOGGLE: do_toggle = in_xfer;
      CMD_LOAD:   do_load   = in_xfer;
      default: ;
    endcase
  end

  assign yr_prod = 25'(year_i) * 25'(YEAR_RECIP);
  assign yr_quot = yr_prod[YEAR_SHIFT +: 6];
  assign yr_rem  = year_i - 12'(yr_quot) * 12'd100;

  always_comb begin
    pos = (scan_idx_q >= IDX_W'(DIGIT_COUNT)) ? '0 : scan_idx_q;
    case (pos[IDX_W-1:1])
      2'd0:    val = show_date_q ? year_lo_q : 7'(sec_q);
      2'd1:    val = show_date_q ? 7'(month_q) : 7'(min_q);
      default: val = show_date_q ? 7'(day_q) : 7'(hour_q);
    endcase
    tens_prod = 14'(val) * 14'(TENS_RECIP);
    tens      = tens_prod[TENS_SHIFT +: 4];
    ones      = 4'(val - 7'(tens) * 7'd10);
    digit     = pos[0] ? tens : ones;

    res.segments     = seg_lookup(digit);
    res.digit_select = DIGIT_COUNT'(1) << pos;
    res.point_off    = (pos == IDX_W'(2) || pos == IDX_W'(4)) ? POINT_ALL_ON : POINT_ALL_OFF;

    scan_idx_d  = (pos == IDX_W'(DIGIT_COUNT - 1)) ? '0 : pos + IDX_W'(1);
    show_date_d = show_date_q ^ 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_idx_q  <= '0;
      show_date_q <= 1'b0;
      sec_q       <= '0;
      min_q       <= '0;
      hour_q      <= '0;
      day_q       <= '0;
      month_q     <= '0;
      year_lo_q   <= '0;
    end else begin
      if (do_scan) begin
        scan_idx_q <= scan_idx_d;
      end
      if (do_toggle) begin
        show_date_q <= show_date_d;
      end
      if (do_load) begin
        sec_q     <= second_i;
        min_q     <= minute_i;
        hour_q    <= hour_i;
        day_q     <= day_of_month_i;
        month_q   <= month_i;
        year_lo_q <= yr_rem[6:0];
      end
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= do_scan;
      end
    end else if (do_scan) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (do_scan) begin
        out_q <= res;
      end
    end else if (do_scan) begin
      skid_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign segments_o     = out_q.segments;
  assign digit_select_o = out_q.digit_select;
  assign point_off_o    = out_q.point_off;

endmodule

// File: sv/ccs_checker.sv
`include "assert_macros.svh"

module ccs_checker (
  input logic                                  clk_i,
  input logic                                  rst_ni,
  input logic                                  in_valid_i,
  input logic                                  in_stall_o,
  input logic [1:0]                            command_i,
  input logic                                  out_valid_o,
  input logic                                  out_stall_i,
  input logic [ccs_pkg::SEG_W-1:0]             segments_o,
  input logic [ccs_pkg::DIGIT_COUNT-1:0]       digit_select_o,
  input logic [ccs_pkg::POINT_W-1:0]           point_off_o
);
  import ccs_pkg::*;

  logic scan_xfer;
  assign scan_xfer = in_valid_i && !in_stall_o && (command_i == CMD_SCAN);

  `CCS_ASSERT(a_sel_onehot, !out_valid_o || $onehot(digit_select_o), "digit select not one-hot")

  `CCS_ASSERT(a_point_match, !out_valid_o || ((point_off_o == POINT_ALL_ON) == (digit_select_o[2] || digit_select_o[4])) && (point_off_o == POINT_ALL_ON || point_off_o == POINT_ALL_OFF), "point control does not match digit")

  `CCS_ASSERT(a_stall_needs_out, !in_stall_o || out_valid_o, "input stalled with empty output")

  `CCS_ASSERT_NEXT(a_no_invented, !out_valid_o && !scan_xfer, !out_valid_o, "result without scan transfer")

  `CCS_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(segments_o) && $stable(digit_select_o) && $stable(point_off_o), "stalled result changed")

endmodule

bind clock_calendar_7seg_scanner ccs_checker u_ccs_checker (.*);
